// File: rtl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

  typedef logic [127:0] block_t;

  localparam int NumRounds = 10;

  // configuration register indexes
  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] RCON [NumRounds] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
  };

  // byte i of a block sits at bits [127-8i -: 8]
  function automatic logic [7:0] get_byte(input block_t b, input int i);
    return b[127 - 8 * i -: 8];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // next round key from the previous one
  function automatic block_t next_key(input block_t k, input logic [7:0] rc);
    logic [31:0] w [4];
    logic [31:0] t;
    block_t r;
    for (int i = 0; i < 4; i++) w[i] = k[127 - 32 * i -: 32];
    t = {SBOX[w[3][23:16]] ^ rc, SBOX[w[3][15:8]], SBOX[w[3][7:0]], SBOX[w[3][31:24]]};
    w[0] = w[0] ^ t;
    w[1] = w[1] ^ w[0];
    w[2] = w[2] ^ w[1];
    w[3] = w[3] ^ w[2];
    r = {w[0], w[1], w[2], w[3]};
    return r;
  endfunction

  // subbytes and shiftrows, then optional mixcolumns
  function automatic block_t round_fn(input block_t s, input logic mix);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    block_t r;
    for (int c = 0; c < 4; c++)
      for (int rr = 0; rr < 4; rr++)
        t[rr + 4 * c] = SBOX[get_byte(s, rr + 4 * ((c + rr) % 4))];
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
        all = a0 ^ a1 ^ a2 ^ a3;
        t[4 * c]     = a0 ^ all ^ xtime(a0 ^ a1);
        t[4 * c + 1] = a1 ^ all ^ xtime(a1 ^ a2);
        t[4 * c + 2] = a2 ^ all ^ xtime(a2 ^ a3);
        t[4 * c + 3] = a3 ^ all ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127 - 8 * i -: 8] = t[i];
    return r;
  endfunction

endpackage

// File: rtl/aes_round.sv
`timescale 1ns / 1ps
module aes_round import aes_pkg::*; #(
  parameter logic [7:0] Rcon = 8'h01,
  parameter bit Mix = 1'b1
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  logic   in_valid,
  input  block_t in_state,
  input  block_t in_key,
  output logic   out_valid,
  output block_t out_state,
  output block_t out_key
);

  block_t key_next;

  assign key_next = next_key(in_key, Rcon);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_state <= round_fn(in_state, Mix) ^ key_next;
      out_key   <= key_next;
    end
  end

endmodule

// File: rtl/aes128_block_encrypt.sv
`timescale 1ns / 1ps
// channel | dir | fields (low bit up)
// s_axis  | in  | tdata: plain_high[63:0], plain_low[127:64]
// m_axis  | out | tdata: cipher_high[63:0], cipher_low[127:64]
// cfg     | in  | cfg_we, cfg_addr (0 key_high, 1 key_low), cfg_wdata
// eleven register stages: initial addroundkey, then one per round
// one block per cycle while the output stage is not stalled
// the whole pipe advances when the output stage is empty or taken
// rst clears the valid bits and the key to zero
module aes128_block_encrypt import aes_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_addr,
  input  logic [63:0]  cfg_wdata,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // plain_high, plain_low
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // cipher_high, cipher_low
);

  logic [63:0] key_high, key_low;
  logic        en;
  logic        v [NumRounds + 1];
  block_t      st [NumRounds + 1];
  block_t      rk [NumRounds + 1];

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0;
      key_low  <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == RegKeyHigh) key_high <= cfg_wdata;
      else                        key_low  <= cfg_wdata;
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= {s_axis_tdata[63:0], s_axis_tdata[127:64]} ^ {key_high, key_low};
      rk[0] <= {key_high, key_low};
    end
  end

  for (genvar r = 1; r <= NumRounds; r++) begin : g_round
    aes_round #(.Rcon(RCON[r - 1]), .Mix(r != NumRounds)) u_round (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (v[r - 1]),
      .in_state (st[r - 1]),
      .in_key   (rk[r - 1]),
      .out_valid(v[r]),
      .out_state(st[r]),
      .out_key  (rk[r])
    );
  end

  assign m_axis_tvalid = v[NumRounds];
  assign m_axis_tdata  = {st[NumRounds][63:0], st[NumRounds][127:64]};

endmodule
